### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    // DEPTH must be a power of two so that ring indexes wrap by truncation.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_FRONT      = 3'd4,
        OP_BACK       = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DATA = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

    typedef struct packed {
        logic exec;
        logic load;
    } cmd_t;

endpackage

### sv/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/deq_ctrl.sv
// Controller state machine: input and output handshakes and datapath commands.
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output deq_pkg::cmd_t cmd
);

    deq_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    logic            accept;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = deq_pkg::S_BUSY;
                end
            end
            deq_pkg::S_BUSY:
            begin
                if (out_free && !accept)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            deq_pkg::S_BUSY:
            begin
                in_ready = out_free;
                cmd.load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.exec = accept;
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/deq_datapath.sv
// Datapath: ring pointers, element RAM, result and output registers.
module deq_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::cmd_t                    cmd,
    input  logic [2:0]                       opcode,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output logic [1:0]                       status,
    output logic signed [deq_pkg::DATA_W-1:0] data,
    output logic [deq_pkg::CNT_W-1:0]        occupancy
);

    logic [deq_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg, count_next;
    deq_pkg::status_t           res_status_reg, res_status_next;
    logic [deq_pkg::CNT_W-1:0]  res_occ_reg;
    logic [1:0]                 status_reg;
    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::CNT_W-1:0]  occupancy_reg;

    logic                       full;
    logic                       empty;
    logic [deq_pkg::ADDR_W-1:0] head_dec;
    logic [deq_pkg::ADDR_W-1:0] tail_slot;
    logic [deq_pkg::ADDR_W-1:0] back_slot;
    logic                       ram_we;
    logic [deq_pkg::ADDR_W-1:0] ram_waddr;
    logic                       ram_re;
    logic [deq_pkg::ADDR_W-1:0] ram_raddr;
    logic [deq_pkg::DATA_W-1:0] ram_rdata;
    deq_pkg::op_t               op;

    assign op        = deq_pkg::op_t'(opcode);
    assign full      = count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH);
    assign empty     = count_reg == '0;
    assign head_dec  = head_reg - deq_pkg::ADDR_W'(1);
    assign tail_slot = head_reg + count_reg[deq_pkg::ADDR_W-1:0];
    assign back_slot = tail_slot - deq_pkg::ADDR_W'(1);

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = deq_pkg::ST_OK;
        ram_we          = 1'b0;
        ram_waddr       = tail_slot;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        if (cmd.exec)
        begin
            unique case (op) inside
                deq_pkg::OP_PUSH_FRONT,
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        res_status_next = deq_pkg::ST_ERR;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + deq_pkg::CNT_W'(1);
                        if (op == deq_pkg::OP_PUSH_FRONT)
                        begin
                            ram_waddr = head_dec;
                            head_next = head_dec;
                        end
                    end
                end
                deq_pkg::OP_POP_FRONT,
                deq_pkg::OP_POP_BACK,
                deq_pkg::OP_FRONT,
                deq_pkg::OP_BACK:
                begin
                    if (empty)
                    begin
                        res_status_next = deq_pkg::ST_ERR;
                    end
                    else
                    begin
                        res_status_next = deq_pkg::ST_DATA;
                        ram_re          = 1'b1;
                        if (op == deq_pkg::OP_POP_BACK || op == deq_pkg::OP_BACK)
                        begin
                            ram_raddr = back_slot;
                        end
                        if (op == deq_pkg::OP_POP_FRONT)
                        begin
                            head_next = head_reg + deq_pkg::ADDR_W'(1);
                        end
                        if (op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_POP_BACK)
                        begin
                            count_next = count_reg - deq_pkg::CNT_W'(1);
                        end
                    end
                end
                deq_pkg::OP_SIZE:
                begin
                    res_status_next = deq_pkg::ST_OK;
                end
                deq_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    res_status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_occ_reg    <= count_next;
        end
        if (cmd.load)
        begin
            status_reg    <= res_status_reg;
            occupancy_reg <= res_occ_reg;
            data_reg      <= (res_status_reg == deq_pkg::ST_DATA) ? ram_rdata : '0;
        end
    end

    assign status    = status_reg;
    assign data      = data_reg;
    assign occupancy = occupancy_reg;

endmodule

### sv/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit values.
//
// The input channel (in_valid, in_ready, opcode, value) takes one command per
// transfer; the output channel (out_valid, out_ready, status, data, occupancy)
// returns exactly one result per command, in order.
// Elements live in a 256-entry ring buffer RAM with a head index and a count.
// A command executes in the cycle of its transfer: pushes write the RAM and
// pops or peeks read it into the registered RAM output at the transfer edge.
// The result is loaded into the output register, raising out_valid, as soon as
// that register is free after the input transfer.
// Throughput is one command per cycle while the receiver keeps out_ready
// high; the single RAM port per direction and the output register set this.
// When the receiver stalls, one result waits in the output register and one
// more command can be taken and held in execution; after that in_ready stays
// low until the output register is freed.
// Reset empties the queue and sets the head index to zero; the RAM contents
// are not cleared, since only occupied entries are ever read.
module double_ended_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [deq_pkg::DATA_W-1:0]  data,
    output logic [deq_pkg::CNT_W-1:0]          occupancy
);

    deq_pkg::cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    deq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .opcode    (opcode),
        .value     (value),
        .status    (status),
        .data      (data),
        .occupancy (occupancy)
    );

endmodule

### bench/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue, with a built-in predictor and random idling.
module tb_double_ended_queue;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        deq_pkg::status_t                   status;
        logic signed [deq_pkg::DATA_W-1:0]  data;
        logic [deq_pkg::CNT_W-1:0]          occupancy;
    } result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [2:0]                         opcode = deq_pkg::OP_PUSH_FRONT;
    logic signed [deq_pkg::DATA_W-1:0]  value = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [1:0]                         status;
    logic signed [deq_pkg::DATA_W-1:0]  data;
    logic [deq_pkg::CNT_W-1:0]          occupancy;

    logic signed [deq_pkg::DATA_W-1:0]  ring_mem [deq_pkg::DEPTH];
    logic [deq_pkg::ADDR_W-1:0]         ring_head = '0;
    logic [deq_pkg::CNT_W-1:0]          ring_fill = '0;
    result_t                            pending_results [$];
    int                                 mismatch_count = 0;
    int                                 cycle_count = 0;
    bit                                 steady = 1'b0;

    double_ended_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .occupancy (occupancy)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int draw_gap();
        if (steady)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic logic signed [deq_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic result_t deque_apply(deq_pkg::op_t op,
                                            logic signed [deq_pkg::DATA_W-1:0] val);
        result_t                    r;
        logic [deq_pkg::ADDR_W-1:0] back_slot;
        r.status  = deq_pkg::ST_OK;
        r.data    = '0;
        back_slot = deq_pkg::ADDR_W'(ring_head + ring_fill - 1);
        case (op) inside
            deq_pkg::OP_PUSH_FRONT:
                if (ring_fill == deq_pkg::DEPTH)
                    r.status = deq_pkg::ST_ERR;
                else
                begin
                    ring_head           = ring_head - 1'b1;
                    ring_mem[ring_head] = val;
                    ring_fill           = ring_fill + 1'b1;
                end
            deq_pkg::OP_PUSH_BACK:
                if (ring_fill == deq_pkg::DEPTH)
                    r.status = deq_pkg::ST_ERR;
                else
                begin
                    ring_mem[deq_pkg::ADDR_W'(ring_head + ring_fill)] = val;
                    ring_fill = ring_fill + 1'b1;
                end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_FRONT:
                if (ring_fill == 0)
                    r.status = deq_pkg::ST_ERR;
                else
                begin
                    r.status = deq_pkg::ST_DATA;
                    r.data   = ring_mem[ring_head];
                    if (op == deq_pkg::OP_POP_FRONT)
                    begin
                        ring_head = ring_head + 1'b1;
                        ring_fill = ring_fill - 1'b1;
                    end
                end
            deq_pkg::OP_POP_BACK, deq_pkg::OP_BACK:
                if (ring_fill == 0)
                    r.status = deq_pkg::ST_ERR;
                else
                begin
                    r.status = deq_pkg::ST_DATA;
                    r.data   = ring_mem[back_slot];
                    if (op == deq_pkg::OP_POP_BACK)
                        ring_fill = ring_fill - 1'b1;
                end
            deq_pkg::OP_CLEAR:
                ring_fill = '0;
            default:
                ;
        endcase
        r.occupancy = ring_fill;
        return r;
    endfunction

    task automatic send_command(input deq_pkg::op_t op,
                                input logic signed [deq_pkg::DATA_W-1:0] val);
        int      gap;
        result_t r;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        r = deque_apply(op, val);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_empty_and_basic();
        send_command(deq_pkg::OP_POP_FRONT, rand_value());
        send_command(deq_pkg::OP_POP_BACK, rand_value());
        send_command(deq_pkg::OP_FRONT, rand_value());
        send_command(deq_pkg::OP_BACK, rand_value());
        send_command(deq_pkg::OP_SIZE, rand_value());
        send_command(deq_pkg::OP_CLEAR, rand_value());
        send_command(deq_pkg::OP_PUSH_FRONT, {1'b1, {(deq_pkg::DATA_W-1){1'b0}}});
        send_command(deq_pkg::OP_PUSH_BACK, {1'b0, {(deq_pkg::DATA_W-1){1'b1}}});
        send_command(deq_pkg::OP_FRONT, '0);
        send_command(deq_pkg::OP_BACK, '0);
        send_command(deq_pkg::OP_SIZE, '1);
        send_command(deq_pkg::OP_PUSH_FRONT, '0);
        send_command(deq_pkg::OP_PUSH_BACK, '1);
        send_command(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
        send_command(deq_pkg::OP_PUSH_BACK, 32'hAAAA_AAAA);
        send_command(deq_pkg::OP_POP_BACK, '0);
        send_command(deq_pkg::OP_POP_FRONT, '0);
        send_command(deq_pkg::OP_BACK, '0);
        send_command(deq_pkg::OP_FRONT, '0);
        send_command(deq_pkg::OP_CLEAR, '1);
        send_command(deq_pkg::OP_FRONT, '0);
        send_command(deq_pkg::OP_PUSH_BACK, 32'sd123);
        send_command(deq_pkg::OP_BACK, '0);
        send_command(deq_pkg::OP_POP_FRONT, '0);
    endtask

    task automatic test_full_queue();
        wait_for_results();
        steady = 1'b1;
        for (int i = 0; i < deq_pkg::DEPTH; i++)
            send_command(i % 2 ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                         rand_value());
        send_command(deq_pkg::OP_PUSH_FRONT, rand_value());
        send_command(deq_pkg::OP_PUSH_BACK, rand_value());
        send_command(deq_pkg::OP_FRONT, '0);
        send_command(deq_pkg::OP_BACK, '0);
        send_command(deq_pkg::OP_SIZE, '0);
        steady = 1'b0;
        for (int i = 0; i < deq_pkg::DEPTH; i++)
            send_command(i % 3 ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                         rand_value());
        send_command(deq_pkg::OP_POP_FRONT, rand_value());
    endtask

    task automatic test_random_mix();
        int           pick;
        deq_pkg::op_t op;
        for (int k = 0; k < 430; k++)
        begin
            if (k % 100 == 50)
                wait_for_results();
            steady = (k >= 200 && k < 260);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = deq_pkg::op_t'(deq_pkg::OP_PUSH_FRONT + $urandom_range(0, 1));
            else if (pick < 75)
                op = deq_pkg::op_t'(deq_pkg::OP_POP_FRONT + $urandom_range(0, 1));
            else if (pick < 90)
                op = deq_pkg::op_t'(deq_pkg::OP_FRONT + $urandom_range(0, 1));
            else if (pick < 97)
                op = deq_pkg::OP_SIZE;
            else
                op = deq_pkg::OP_CLEAR;
            send_command(op, rand_value());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        result_t exp_res;
        int      stall;
        wait (rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, status);
                    mismatch_count++;
                end
                if (data !== exp_res.data)
                begin
                    $error("data: expected %0d, actual %0d", exp_res.data, data);
                    mismatch_count++;
                end
                if (occupancy !== exp_res.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_res.occupancy, occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("double_ended_queue verification failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_basic();
        test_full_queue();
        test_random_mix();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("double_ended_queue verification clean");
        else
            $display("double_ended_queue verification failed");
        $finish;
    end

endmodule
